### hw/rtl/vrp_pkg.sv
// Shared types, codes and helper functions for the video register port.
package vrp_pkg;

    localparam int PATTERN_BYTES_DEF = 8192;
    localparam int NAMETABLE_BYTES   = 1024;
    localparam int SPRITE_MEM_BYTES  = 256;
    localparam int PALETTE_BYTES     = 32;
    localparam int NT_DEPTH          = 4 * NAMETABLE_BYTES;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 40;

    // operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // register indexes
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // mirroring modes
    localparam logic [1:0] MIR_HORZ   = 2'd0;
    localparam logic [1:0] MIR_VERT   = 2'd1;
    localparam logic [1:0] MIR_SINGLE = 2'd2;
    localparam logic [1:0] MIR_FOUR   = 2'd3;

    // VRAM target select
    localparam logic [1:0] VSEL_PAT = 2'd0;
    localparam logic [1:0] VSEL_NT  = 2'd1;
    localparam logic [1:0] VSEL_PAL = 2'd2;

    typedef struct packed {
        logic        oam_re;
        logic        oam_we;
        logic [7:0]  oam_addr;
        logic        vram_re;
        logic        vram_we;
        logic [1:0]  vram_sel;
        logic [12:0] pat_addr;
        logic [11:0] nt_addr;
        logic [4:0]  pal_addr;
        logic [7:0]  wdata;
    } vrp_mem_req_t;

    typedef struct packed {
        logic        oam_rd;
        logic [7:0]  rd;
        logic        nmi;
        logic [7:0]  rc;
        logic [14:0] temp;
        logic [2:0]  fine_x;
    } vrp_result_t;

    function automatic logic [1:0] table_map(input logic [1:0] mode, input logic [1:0] quad);
        logic [1:0] tbl;
        case (mode)
            MIR_HORZ:   tbl = {1'b0, quad[1]};
            MIR_VERT:   tbl = {1'b0, quad[0]};
            MIR_SINGLE: tbl = 2'd0;
            MIR_FOUR:   tbl = quad;
            default:    tbl = 2'd0;
        endcase
        return tbl;
    endfunction

    // backdrop entries 0x10/0x14/0x18/0x1C alias the lower half
    function automatic logic [4:0] palette_index(input logic [4:0] a);
        logic [4:0] idx;
        idx = a;
        if (a[4] && (a[1:0] == 2'b00))
        begin
            idx[4] = 1'b0;
        end
        return idx;
    endfunction

endpackage

### hw/rtl/vrp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/vrp_core.sv
// Register state, VRAM address map and memory access generation.
module vrp_core #(
    parameter int PATTERN_BYTES = vrp_pkg::PATTERN_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic                 acc,
    input  logic [1:0]           op,
    input  logic [2:0]           ridx,
    input  logic [7:0]           wdata,
    input  logic [2:0]           flags,
    input  logic [7:0]           pat_rdata,
    input  logic [7:0]           nt_rdata,
    input  logic [7:0]           pal_rdata,
    output vrp_pkg::vrp_mem_req_t req,
    output vrp_pkg::vrp_result_t  res
);

    localparam logic [13:0] PB = 14'(PATTERN_BYTES);

    logic [1:0]  mode_reg;
    logic [14:0] temp_reg, temp_next;
    logic [14:0] ptr_reg, ptr_next;
    logic        w_reg, w_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic [4:0]  ctrl_reg, ctrl_next;
    logic [4:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [4:0]  lwl_reg, lwl_next;
    logic [7:0]  oam_addr_reg, oam_addr_next;
    logic        pend_reg, pend_next;
    logic [1:0]  sel_reg, sel_next;

    logic [13:0] va;
    logic [13:0] pat_wide;
    logic [1:0]  vsel;
    logic [7:0]  buf_val;
    logic [7:0]  rd;
    logic        nmi;
    logic        oam_rd;
    logic        vram_re;
    logic        vram_we;
    logic [14:0] ptr_inc;

    assign va       = ptr_reg[13:0];
    assign pat_wide = {1'b0, va[12:0]};
    assign ptr_inc  = ptr_reg + (ctrl_reg[0] ? 15'd32 : 15'd1);

    always_comb
    begin
        if (!va[13])
        begin
            vsel = vrp_pkg::VSEL_PAT;
        end
        else if (va[13:8] == 6'h3F)
        begin
            vsel = vrp_pkg::VSEL_PAL;
        end
        else
        begin
            vsel = vrp_pkg::VSEL_NT;
        end
    end

    always_comb
    begin
        case (sel_reg)
            vrp_pkg::VSEL_PAT: buf_val = pat_rdata;
            vrp_pkg::VSEL_NT:  buf_val = nt_rdata;
            default:           buf_val = pal_rdata;
        endcase
        if (!pend_reg)
        begin
            buf_val = 8'd0;
        end
    end

    always_comb
    begin
        temp_next     = temp_reg;
        ptr_next      = ptr_reg;
        w_next        = w_reg;
        fine_x_next   = fine_x_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        lwl_next      = lwl_reg;
        oam_addr_next = oam_addr_reg;
        pend_next     = pend_reg;
        sel_next      = sel_reg;
        rd            = 8'd0;
        nmi           = 1'b0;
        oam_rd        = 1'b0;
        vram_re       = 1'b0;
        vram_we       = 1'b0;
        case (op)
            vrp_pkg::OP_READ:
            begin
                case (ridx)
                    vrp_pkg::REG_STATUS:
                    begin
                        rd          = {status_reg, lwl_reg};
                        status_next = {1'b0, status_reg[1:0]};
                        w_next      = 1'b0;
                    end
                    vrp_pkg::REG_OAMDATA:
                    begin
                        oam_rd = 1'b1;
                    end
                    vrp_pkg::REG_DATA:
                    begin
                        rd        = buf_val;
                        vram_re   = 1'b1;
                        pend_next = 1'b1;
                        sel_next  = vsel;
                        ptr_next  = ptr_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
            vrp_pkg::OP_WRITE:
            begin
                case (ridx)
                    vrp_pkg::REG_CTRL:
                    begin
                        temp_next = {temp_reg[14:12], wdata[1:0], temp_reg[9:0]};
                        nmi       = status_reg[2] & ~ctrl_reg[4] & wdata[7];
                        ctrl_next = {wdata[7], wdata[5], wdata[4], wdata[3], wdata[2]};
                        lwl_next  = wdata[4:0];
                    end
                    vrp_pkg::REG_MASK:
                    begin
                        mask_next = wdata[4:0];
                        lwl_next  = wdata[4:0];
                    end
                    vrp_pkg::REG_OAMADDR:
                    begin
                        oam_addr_next = wdata;
                        lwl_next      = wdata[4:0];
                    end
                    vrp_pkg::REG_OAMDATA:
                    begin
                        oam_addr_next = oam_addr_reg + 8'd1;
                    end
                    vrp_pkg::REG_SCROLL:
                    begin
                        if (w_reg)
                        begin
                            temp_next = {wdata[2:0], temp_reg[11:10], wdata[7:3],
                                         temp_reg[4:0]};
                            w_next    = 1'b0;
                        end
                        else
                        begin
                            temp_next   = {temp_reg[14:5], wdata[7:3]};
                            fine_x_next = wdata[2:0];
                            w_next      = 1'b1;
                        end
                        lwl_next = wdata[4:0];
                    end
                    vrp_pkg::REG_ADDR:
                    begin
                        if (w_reg)
                        begin
                            temp_next = {temp_reg[14:8], wdata};
                            ptr_next  = {temp_reg[14:8], wdata};
                            w_next    = 1'b0;
                        end
                        else
                        begin
                            temp_next = {1'b0, wdata[5:0], temp_reg[7:0]};
                            w_next    = 1'b1;
                        end
                        lwl_next = wdata[4:0];
                    end
                    vrp_pkg::REG_DATA:
                    begin
                        vram_we  = 1'b1;
                        ptr_next = ptr_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
            vrp_pkg::OP_STATUS:
            begin
                status_next = flags;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= vrp_pkg::MIR_HORZ;
            temp_reg     <= '0;
            ptr_reg      <= '0;
            w_reg        <= 1'b0;
            fine_x_reg   <= '0;
            ctrl_reg     <= '0;
            mask_reg     <= '0;
            status_reg   <= 3'b100;
            lwl_reg      <= '0;
            oam_addr_reg <= '0;
            pend_reg     <= 1'b0;
            sel_reg      <= vrp_pkg::VSEL_PAT;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (acc)
            begin
                temp_reg     <= temp_next;
                ptr_reg      <= ptr_next;
                w_reg        <= w_next;
                fine_x_reg   <= fine_x_next;
                ctrl_reg     <= ctrl_next;
                mask_reg     <= mask_next;
                status_reg   <= status_next;
                lwl_reg      <= lwl_next;
                oam_addr_reg <= oam_addr_next;
                pend_reg     <= pend_next;
                sel_reg      <= sel_next;
            end
        end
    end

    always_comb
    begin
        req.oam_re   = acc & oam_rd;
        req.oam_we   = acc & (op == vrp_pkg::OP_WRITE) & (ridx == vrp_pkg::REG_OAMDATA);
        req.oam_addr = oam_addr_reg;
        req.vram_re  = acc & vram_re;
        req.vram_we  = acc & vram_we;
        req.vram_sel = vsel;
        req.pat_addr = (pat_wide >= PB) ? 13'(pat_wide - PB) : va[12:0];
        req.nt_addr  = {vrp_pkg::table_map(mode_reg, va[11:10]), va[9:0]};
        req.pal_addr = vrp_pkg::palette_index(va[4:0]);
        req.wdata    = wdata;
    end

    always_comb
    begin
        res.oam_rd = oam_rd;
        res.rd     = rd;
        res.nmi    = nmi;
        res.rc     = {mask_next, ctrl_next[3:1]};
        res.temp   = temp_next;
        res.fine_x = fine_x_next;
    end

endmodule

### hw/rtl/video_register_port_with_vram_map_top.sv
// Top level of the video register port with VRAM map.
//
// CPU register accesses enter on the s_axis channel, one beat per access:
// tuser carries the operation and register index, tdata the write byte and
// the renderer's status flags. Each beat yields exactly one m_axis beat with
// the read byte, the NMI request, render controls, temporary address and
// fine X. cfg_we/cfg_wdata set the nametable mirroring mode.
// Each beat passes the internal stage, then the output register; one beat is
// taken every cycle unless a stall or the memory clear blocks input. Sprite
// memory, nametables, palette and pattern memory are single-port-read
// synchronous RAMs; a data read returns the buffered byte held in the VRAM read
// register and refills it with the current access. After reset the block clears
// sprite, nametable and palette memory with s_axis_tready low; configuration
// writes still land. When m_axis_tready is low the output beat holds and one
// more input beat is absorbed in the internal stage before s_axis_tready drops.
module video_register_port_with_vram_map_top #(
    parameter int PATTERN_BYTES = vrp_pkg::PATTERN_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [vrp_pkg::IN_DATA_W-1:0] s_axis_tdata,  // write_data, status_flags
    input  logic [vrp_pkg::IN_USER_W-1:0] s_axis_tuser,  // operation, register_index
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data, nmi_request, render_controls, temp_address_out, fine_x_scroll
    output logic [vrp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(vrp_pkg::NT_DEPTH);
    localparam int OAM_AW = $clog2(vrp_pkg::SPRITE_MEM_BYTES);
    localparam int PAL_AW = $clog2(vrp_pkg::PALETTE_BYTES);

    vrp_pkg::vrp_mem_req_t req;
    vrp_pkg::vrp_result_t  res;
    vrp_pkg::vrp_result_t  s1_reg;

    logic              acc;
    logic              out_free;
    logic              s1_adv;
    logic              s1_v_reg;
    logic              out_v_reg;
    logic [vrp_pkg::OUT_DATA_W-1:0] out_reg;
    logic              clr_busy_reg;
    logic [NT_AW-1:0]  clr_cnt_reg;
    logic [7:0]        oam_rdata;
    logic [7:0]        pat_rdata;
    logic [7:0]        nt_rdata;
    logic [7:0]        pal_rdata;
    logic [7:0]        out_rd;

    assign out_free      = !out_v_reg || m_axis_tready;
    assign s1_adv        = s1_v_reg && out_free;
    assign s_axis_tready = !clr_busy_reg && (!s1_v_reg || out_free);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;
    assign out_rd        = s1_reg.oam_rd ? oam_rdata : s1_reg.rd;

    vrp_core #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .acc      (acc),
        .op       (s_axis_tuser[1:0]),
        .ridx     (s_axis_tuser[4:2]),
        .wdata    (s_axis_tdata[7:0]),
        .flags    (s_axis_tdata[10:8]),
        .pat_rdata(pat_rdata),
        .nt_rdata (nt_rdata),
        .pal_rdata(pal_rdata),
        .req      (req),
        .res      (res)
    );

    vrp_ram #(
        .WIDTH(8),
        .DEPTH(vrp_pkg::SPRITE_MEM_BYTES)
    ) u_oam_ram (
        .clk  (clk),
        .we   (clr_busy_reg || req.oam_we),
        .waddr(clr_busy_reg ? clr_cnt_reg[OAM_AW-1:0] : req.oam_addr),
        .wdata(clr_busy_reg ? 8'd0 : req.wdata),
        .re   (req.oam_re),
        .raddr(req.oam_addr),
        .rdata(oam_rdata)
    );

    vrp_ram #(
        .WIDTH(8),
        .DEPTH(vrp_pkg::NT_DEPTH)
    ) u_nt_ram (
        .clk  (clk),
        .we   (clr_busy_reg || (req.vram_we && req.vram_sel == vrp_pkg::VSEL_NT)),
        .waddr(clr_busy_reg ? clr_cnt_reg : req.nt_addr),
        .wdata(clr_busy_reg ? 8'd0 : req.wdata),
        .re   (req.vram_re && req.vram_sel == vrp_pkg::VSEL_NT),
        .raddr(req.nt_addr),
        .rdata(nt_rdata)
    );

    vrp_ram #(
        .WIDTH(8),
        .DEPTH(vrp_pkg::PALETTE_BYTES)
    ) u_pal_ram (
        .clk  (clk),
        .we   (clr_busy_reg || (req.vram_we && req.vram_sel == vrp_pkg::VSEL_PAL)),
        .waddr(clr_busy_reg ? clr_cnt_reg[PAL_AW-1:0] : req.pal_addr),
        .wdata(clr_busy_reg ? 8'd0 : req.wdata),
        .re   (req.vram_re && req.vram_sel == vrp_pkg::VSEL_PAL),
        .raddr(req.pal_addr),
        .rdata(pal_rdata)
    );

    vrp_ram #(
        .WIDTH(8),
        .DEPTH(PATTERN_BYTES)
    ) u_pat_ram (
        .clk  (clk),
        .we   (req.vram_we && req.vram_sel == vrp_pkg::VSEL_PAT),
        .waddr(req.pat_addr[PAT_AW-1:0]),
        .wdata(req.wdata),
        .re   (req.vram_re && req.vram_sel == vrp_pkg::VSEL_PAT),
        .raddr(req.pat_addr[PAT_AW-1:0]),
        .rdata(pat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NT_AW'(vrp_pkg::NT_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (acc)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= res;
        end
        if (s1_adv)
        begin
            out_reg <= {5'd0, s1_reg.fine_x, s1_reg.temp, s1_reg.rc, s1_reg.nmi, out_rd};
        end
    end

endmodule

### hw/rtl/vrp_checker.sv
// Port-level assertions for the video register port, bound to the top level.
module vrp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [vrp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output payload changed while stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_beat, 2))
        else $error("output beat without input beat two cycles earlier");

    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output beat drains");

endmodule

bind video_register_port_with_vram_map_top vrp_checker u_vrp_checker (.*);

### dv/video_register_port_with_vram_map_top_tb.sv
// Self-checking testbench for the video register port: directed table, random CPU traffic.
module video_register_port_with_vram_map_top_tb;

    import vrp_pkg::*;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam int         PAT_BYTES   = PATTERN_BYTES_DEF;
    localparam int         STALL_LIMIT = 20000;
    localparam int         HOLD_AT     = 150;
    localparam int         HOLD_CYCLES = 400;
    localparam int         SWEEP_BEATS = 530;
    localparam int         PHASE_BEATS = 65;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic [2:0]  fx;
        logic [14:0] temp;
        logic [7:0]  rc;
        logic        nmi;
        logic [7:0]  rd;
    } port_beat_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] rg;
        logic [7:0] wd;
        logic [2:0] fl;
        logic       pin;
        logic [7:0] rd;
    } access_row_t;

    localparam access_row_t ACCESS_ROWS [0:27] = '{
        '{OP_READ,   REG_STATUS,  8'h00, 3'd0, 1'b1, 8'h80},
        '{OP_READ,   REG_STATUS,  8'hFF, 3'd7, 1'b1, 8'h00},
        '{OP_READ,   REG_CTRL,    8'hFF, 3'd7, 1'b1, 8'h00},
        '{OP_READ,   REG_MASK,    8'h00, 3'd0, 1'b1, 8'h00},
        '{OP_READ,   REG_OAMADDR, 8'h00, 3'd0, 1'b1, 8'h00},
        '{OP_READ,   REG_SCROLL,  8'h00, 3'd0, 1'b1, 8'h00},
        '{OP_READ,   REG_ADDR,    8'h00, 3'd0, 1'b1, 8'h00},
        '{OP_STATUS, REG_STATUS,  8'h00, 3'd7, 1'b0, 8'h00},
        '{OP_WRITE,  REG_CTRL,    8'h80, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_CTRL,    8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_MASK,    8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_STATUS,  8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_NOP,    REG_DATA,    8'hFF, 3'd7, 1'b1, 8'h00},
        '{OP_WRITE,  REG_OAMADDR, 8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_OAMDATA, 8'hA5, 3'd0, 1'b0, 8'h00},
        '{OP_READ,   REG_OAMDATA, 8'h00, 3'd0, 1'b1, 8'h00},
        '{OP_WRITE,  REG_OAMADDR, 8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_READ,   REG_OAMDATA, 8'h00, 3'd0, 1'b1, 8'hA5},
        '{OP_WRITE,  REG_SCROLL,  8'hFF, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_SCROLL,  8'h00, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_CTRL,    8'h00, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_ADDR,    8'h3F, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_ADDR,    8'h10, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_DATA,    8'h2A, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_ADDR,    8'h3F, 3'd0, 1'b0, 8'h00},
        '{OP_WRITE,  REG_ADDR,    8'h00, 3'd0, 1'b0, 8'h00},
        '{OP_READ,   REG_DATA,    8'h00, 3'd0, 1'b0, 8'h00},
        '{OP_READ,   REG_DATA,    8'h00, 3'd0, 1'b1, 8'h2A}
    };

    localparam logic [1:0] PHASE_MODES [0:5] = '{
        MIR_FOUR, MIR_VERT, MIR_SINGLE, MIR_HORZ, MIR_FOUR, MIR_VERT
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [1:0]             cfg_wdata     = 2'd0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // write_data, status_flags
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;   // operation, register_index
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // read_data, nmi_request, render_controls, temp_address_out, fine_x_scroll
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    video_register_port_with_vram_map_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [1:0]  mirror_mode;
    logic [14:0] tmp_addr;
    logic [14:0] vram_ptr;
    logic        toggle;
    logic [2:0]  fine_x_q;
    logic [4:0]  ctrl_q;
    logic [4:0]  mask_q;
    logic [2:0]  stat_q;
    logic [4:0]  last_low;
    logic [7:0]  rd_buf;
    logic [7:0]  oam_ptr;
    logic [7:0]  oam_mem [SPRITE_MEM_BYTES];
    logic [7:0]  nt_mem  [NT_DEPTH];
    logic [7:0]  pal_mem [PALETTE_BYTES];
    logic [7:0]  pat_mem [PAT_BYTES];
    bit          pat_valid [PAT_BYTES];

    port_beat_t  awaited_beats [$];
    int          beats_sent  = 0;
    int          beats_seen  = 0;
    int          fail_count  = 0;
    int          quiet_cycles = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;

    function automatic int nt_slot(input logic [13:0] a);
        logic [1:0] quad;
        logic [1:0] bank;
        quad = a[11:10];
        case (mirror_mode)
            MIR_HORZ:   bank = quad >> 1;
            MIR_VERT:   bank = quad & 2'b01;
            MIR_SINGLE: bank = 2'd0;
            default:    bank = quad;
        endcase
        return bank * NAMETABLE_BYTES + a[9:0];
    endfunction

    // sprite backdrop slots fold onto the background ones
    function automatic int pal_slot(input logic [4:0] i);
        if (i[4] && i[1:0] == 2'b00)
            return i & 5'h0F;
        return i;
    endfunction

    function automatic logic [7:0] vram_peek(input logic [14:0] p);
        logic [13:0] a;
        a = p[13:0];
        if (a < 14'h2000)
            return pat_mem[a % PAT_BYTES];
        if (a < 14'h3F00)
            return nt_mem[nt_slot(a)];
        return pal_mem[pal_slot(a[4:0])];
    endfunction

    task automatic vram_poke(input logic [14:0] p, input logic [7:0] d);
        logic [13:0] a;
        a = p[13:0];
        if (a < 14'h2000)
        begin
            pat_mem[a % PAT_BYTES]   = d;
            pat_valid[a % PAT_BYTES] = 1'b1;
        end
        else if (a < 14'h3F00)
            nt_mem[nt_slot(a)] = d;
        else
            pal_mem[pal_slot(a[4:0])] = d;
    endtask

    function automatic bit data_read_safe();
        logic [13:0] a;
        a = vram_ptr[13:0];
        return !(a < 14'h2000 && !pat_valid[a % PAT_BYTES]);
    endfunction

    task automatic clear_port_state();
        tmp_addr = '0;
        vram_ptr = '0;
        toggle   = 1'b0;
        fine_x_q = '0;
        ctrl_q   = '0;
        mask_q   = '0;
        stat_q   = 3'b100;
        last_low = '0;
        rd_buf   = '0;
        oam_ptr  = '0;
        mirror_mode = MIR_HORZ;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        foreach (nt_mem[i]) nt_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        foreach (pat_valid[i]) pat_valid[i] = 1'b0;
    endtask

    task automatic run_cpu_access(input logic [1:0] op, input logic [2:0] rg,
                                  input logic [7:0] wd, input logic [2:0] fl,
                                  output port_beat_t res);
        res = '0;
        case (op)
            OP_READ:
            begin
                case (rg)
                    REG_STATUS:
                    begin
                        res.rd    = {stat_q, last_low};
                        stat_q[2] = 1'b0;
                        toggle    = 1'b0;
                    end
                    REG_OAMDATA: res.rd = oam_mem[oam_ptr];
                    REG_DATA:
                    begin
                        res.rd   = rd_buf;
                        rd_buf   = vram_peek(vram_ptr);
                        vram_ptr = vram_ptr + (ctrl_q[0] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            OP_WRITE:
            begin
                case (rg)
                    REG_CTRL:
                    begin
                        res.nmi = stat_q[2] && !ctrl_q[4] && wd[7];
                        tmp_addr[11:10] = wd[1:0];
                        ctrl_q   = {wd[7], wd[5:2]};
                        last_low = wd[4:0];
                    end
                    REG_MASK:
                    begin
                        mask_q   = wd[4:0];
                        last_low = wd[4:0];
                    end
                    REG_OAMADDR:
                    begin
                        oam_ptr  = wd;
                        last_low = wd[4:0];
                    end
                    REG_OAMDATA:
                    begin
                        oam_mem[oam_ptr] = wd;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (toggle)
                        begin
                            tmp_addr[14:12] = wd[2:0];
                            tmp_addr[9:5]   = wd[7:3];
                        end
                        else
                        begin
                            tmp_addr[4:0] = wd[7:3];
                            fine_x_q      = wd[2:0];
                        end
                        toggle   = !toggle;
                        last_low = wd[4:0];
                    end
                    REG_ADDR:
                    begin
                        if (toggle)
                        begin
                            tmp_addr[7:0] = wd;
                            vram_ptr      = tmp_addr;
                        end
                        else
                            tmp_addr = {1'b0, wd[5:0], tmp_addr[7:0]};
                        toggle   = !toggle;
                        last_low = wd[4:0];
                    end
                    REG_DATA:
                    begin
                        vram_poke(vram_ptr, wd);
                        vram_ptr = vram_ptr + (ctrl_q[0] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            OP_STATUS: stat_q = fl;
            default: ;
        endcase
        res.rc   = {mask_q, ctrl_q[3:1]};
        res.temp = tmp_addr;
        res.fx   = fine_x_q;
    endtask

    // data reads that would prefetch unwritten pattern bytes become data writes
    task automatic send_access(input logic [1:0] op, input logic [2:0] rg,
                               input logic [7:0] wd, input logic [2:0] fl,
                               input logic pin, input logic [7:0] pinned_rd);
        int         gap;
        logic [1:0] op_eff;
        port_beat_t res;
        op_eff = op;
        if (op == OP_READ && rg == REG_DATA && !data_read_safe())
            op_eff = OP_WRITE;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {rg, op_eff};
        s_axis_tdata  <= {5'd0, fl, wd};
        do @(posedge clk); while (!s_axis_tready);
        run_cpu_access(op_eff, rg, wd, fl, res);
        if (pin)
            res.rd = pinned_rd;
        awaited_beats.push_back(res);
        beats_sent++;
    endtask

    task automatic cpu_write(input logic [2:0] rg, input logic [7:0] d);
        send_access(OP_WRITE, rg, d, $urandom, 1'b0, 8'h00);
    endtask

    task automatic cpu_read(input logic [2:0] rg);
        send_access(OP_READ, rg, $urandom, $urandom, 1'b0, 8'h00);
    endtask

    task automatic set_mirroring(input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mirror_mode = mode;
    endtask

    task automatic drain_port();
        s_axis_tvalid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_hi();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(8'h00, 8'h1F);
            1:       return $urandom_range(8'h20, 8'h3E);
            2:       return {2'($urandom_range(0, 3)), 6'h3F};
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic set_vram_address(input logic [7:0] hi, input logic [7:0] lo);
        if (toggle && $urandom_range(0, 4) != 0)
            cpu_read(REG_STATUS);
        cpu_write(REG_ADDR, hi);
        cpu_write(REG_ADDR, lo);
    endtask

    task automatic random_traffic(input int n);
        int         stop_at;
        int         kind;
        int         k;
        logic [7:0] hi;
        logic [7:0] lo;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                set_vram_address(pick_hi(), $urandom);
                k = $urandom_range(1, 8);
                repeat (k)
                begin
                    if ($urandom_range(0, 2) == 0)
                        cpu_read(REG_DATA);
                    else
                        cpu_write(REG_DATA, $urandom);
                end
            end
            else if (kind < 45)
            begin
                hi = pick_hi();
                lo = $urandom;
                k  = $urandom_range(1, 6);
                set_vram_address(hi, lo);
                repeat (k) cpu_write(REG_DATA, $urandom);
                set_vram_address(hi, lo);
                repeat (k + 1) cpu_read(REG_DATA);
            end
            else if (kind < 55)
            begin
                if (toggle && $urandom_range(0, 4) != 0)
                    cpu_read(REG_STATUS);
                cpu_write(REG_SCROLL, $urandom);
                cpu_write(REG_SCROLL, $urandom);
            end
            else if (kind < 65)
            begin
                cpu_write(REG_OAMADDR, $urandom);
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    if ($urandom_range(0, 2) == 0)
                        cpu_read(REG_OAMDATA);
                    else
                        cpu_write(REG_OAMDATA, $urandom);
                end
            end
            else if (kind < 72)
                cpu_write(REG_CTRL, $urandom);
            else if (kind < 78)
                cpu_write(REG_MASK, $urandom);
            else if (kind < 85)
                cpu_read(REG_STATUS);
            else if (kind < 90)
                send_access(OP_STATUS, $urandom, $urandom, $urandom, 1'b0, 8'h00);
            else
                send_access($urandom_range(0, 3), $urandom, $urandom, $urandom, 1'b0, 8'h00);
        end
    endtask

    // step by 32 from 0x3FFF far enough that the pointer wraps past 15 bits
    task automatic pointer_sweep();
        logic [7:0] d;
        cpu_read(REG_STATUS);
        d    = $urandom;
        d[2] = 1'b1;
        cpu_write(REG_CTRL, d);
        cpu_write(REG_ADDR, 8'h3F);
        cpu_write(REG_ADDR, 8'hFF);
        repeat (SWEEP_BEATS)
        begin
            if ($urandom_range(0, 6) == 0)
                cpu_read(REG_DATA);
            else
                cpu_write(REG_DATA, $urandom);
        end
    endtask

    // output side: random backpressure plus one long hold
    initial
    begin
        int         stall;
        port_beat_t got;
        port_beat_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (beats_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            beats_seen++;
            got = m_axis_tdata[$bits(port_beat_t)-1:0];
            if (awaited_beats.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected beat: rd=%h nmi=%b rc=%h temp=%h fx=%h",
                             got.rd, got.nmi, got.rc, got.temp, got.fx);
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("beat %0d mismatch: exp rd=%h nmi=%b rc=%h temp=%h fx=%h, got rd=%h nmi=%b rc=%h temp=%h fx=%h",
                                 beats_seen, want.rd, want.nmi, want.rc, want.temp, want.fx,
                                 got.rd, got.nmi, got.rc, got.temp, got.fx);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("video_register_port_with_vram_map_top verification failed");
            $finish;
        end
    end

    initial
    begin
        clear_port_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_mirroring(MIR_HORZ);
        for (int i = 0; i < $size(ACCESS_ROWS); i++)
            send_access(ACCESS_ROWS[i].op, ACCESS_ROWS[i].rg, ACCESS_ROWS[i].wd,
                        ACCESS_ROWS[i].fl, ACCESS_ROWS[i].pin, ACCESS_ROWS[i].rd);
        for (int ph = 0; ph < $size(PHASE_MODES); ph++)
        begin
            drain_port();
            set_mirroring(PHASE_MODES[ph]);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if (ph == 2)
                pointer_sweep();
            random_traffic(PHASE_BEATS);
        end
        drain_port();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("video_register_port_with_vram_map_top verification clean");
        else
            $display("video_register_port_with_vram_map_top verification failed");
        $finish;
    end

endmodule
